// File: design/dwpi_pkg.sv
// Package: shared types, constants and register indexes of the dual wheel PI speed controller.
package dwpi_pkg;

  localparam int unsigned STOP_NUM      = 87000;
  localparam int unsigned QUOT_W        = 17;
  localparam int unsigned DIV_STEPS     = 17;

  localparam logic [15:0] PROP_GAIN_RST = 16'd256;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd16;
  localparam logic [14:0] LIMIT_RST     = 15'd1000;
  localparam logic [7:0]  TIMEOUT_RST   = 8'd100;

  localparam logic signed [16:0] DRIVE_MAX = 17'sd128;
  localparam logic signed [16:0] DRIVE_MIN = -17'sd127;
  localparam logic [7:0]  NEUTRAL       = 8'd127;

  typedef enum logic [1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_LIMIT      = 2'd2,
    REG_TIMEOUT    = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_ERR,
    ST_MULP,
    ST_MULI,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

// File: design/dwpi_div.sv
// Serial restoring divider: constant stop numerator over an 18 bit period magnitude, one bit a cycle.
module dwpi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [17:0] divisor,
  output logic        done,
  output logic [dwpi_pkg::QUOT_W-1:0] quot
);

  localparam logic [dwpi_pkg::QUOT_W-1:0] NUM = dwpi_pkg::QUOT_W'(dwpi_pkg::STOP_NUM);

  logic        busy;
  logic [4:0]  count;
  logic [17:0] rem;
  logic [dwpi_pkg::QUOT_W-1:0] num;
  logic [17:0] dvs;
  logic [18:0] trial;
  logic        fits;

  assign trial = {rem, num[dwpi_pkg::QUOT_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= !start && busy && (count == 5'd1);
      if (start) begin
        busy  <= 1'b1;
        count <= 5'(dwpi_pkg::DIV_STEPS);
      end else if (busy) begin
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      num  <= NUM;
      dvs  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? 18'(trial - {1'b0, dvs}) : trial[17:0];
      num  <= {num[dwpi_pkg::QUOT_W-2:0], 1'b0};
      quot <= {quot[dwpi_pkg::QUOT_W-2:0], fits};
    end
  end

endmodule

// File: design/dwpi_mul.sv
// Shared registered multiplier: unsigned Q8.8 gain times signed operand, floored and wrapped to 16 bits.
module dwpi_mul (
  input  logic               clk,
  input  logic [15:0]        gain,
  input  logic signed [15:0] operand,
  output logic signed [15:0] term
);

  logic signed [32:0] prod;

  assign prod = $signed({1'b0, gain}) * operand;

  always_ff @(posedge clk) begin
    term <= prod[23:8];
  end

endmodule

// File: design/dual_wheel_pi_speed_control_core.sv
// Top level: dual wheel PI speed controller with sequencer, shared divider and multiplier.
// Sequence: each item runs both wheels in turn through start, divide, error, two multiplies
// and sum, the 17 step serial divider dominating each wheel, plus any wait on a stalled result.
// Input stalls while an item is in work; a new item is taken only once the last result is issued.
// Reset: synchronous, clears integrators, silence count and control; registers to defaults.
module dual_wheel_pi_speed_control_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [8:0] setpoint_left,
  input  logic signed [8:0] setpoint_right,
  input  logic signed [17:0] period_left,
  input  logic signed [17:0] period_right,
  input  logic              link_mode,
  input  logic              packet_done,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        drive_left,
  output logic [7:0]        drive_right,
  output logic              link_ok,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  dwpi_pkg::state_t state, state_next;
  logic div_start;
  logic div_done;

  logic [15:0] prop_gain;
  logic [15:0] integ_gain;
  logic [14:0] integral_limit;
  logic [7:0]  link_timeout;

  logic signed [8:0]  sp_l, sp_r;
  logic signed [17:0] per_l, per_r;
  logic               link_r, pkt_r;
  logic               wheel;

  logic signed [15:0] integ_left, integ_right;
  logic [7:0]         silence_count;
  logic signed [15:0] err, acc;
  logic signed [15:0] term_p;
  logic [7:0]         drv_l, drv_r;

  logic signed [8:0]  sp_cur;
  logic signed [17:0] per_cur;
  logic signed [15:0] integ_cur;
  logic [17:0]        mag;
  logic [dwpi_pkg::QUOT_W-1:0] quot;
  logic signed [17:0] q_signed;
  logic signed [18:0] err_wide;
  logic signed [16:0] acc_wide, lim_pos, lim_neg, acc_clamp;
  logic [15:0]        mul_gain;
  logic signed [15:0] mul_op, mul_term;
  logic signed [16:0] sum;
  logic [7:0]         drv;
  logic [8:0]         cnt;
  logic               lost;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  assign sp_cur    = wheel ? sp_r : sp_l;
  assign per_cur   = wheel ? per_r : per_l;
  assign integ_cur = wheel ? integ_right : integ_left;

  always_comb begin
    if (per_cur == '0) begin
      mag = 18'd1;
    end else if (per_cur[17]) begin
      mag = 18'(-per_cur);
    end else begin
      mag = per_cur;
    end
  end

  dwpi_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (mag),
    .done    (div_done),
    .quot    (quot)
  );

  assign q_signed = per_cur[17] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign err_wide = -{{10{sp_cur[8]}}, sp_cur} - {q_signed[17], q_signed};
  assign acc_wide = (sp_cur == '0) ? 17'sd0 :
                    17'({integ_cur[15], integ_cur} + {err_wide[15], err_wide[15:0]});
  assign lim_pos  = $signed({2'b00, integral_limit});
  assign lim_neg  = -lim_pos;

  always_comb begin
    if (acc_wide > lim_pos) begin
      acc_clamp = lim_pos;
    end else if (acc_wide < lim_neg) begin
      acc_clamp = lim_neg;
    end else begin
      acc_clamp = acc_wide;
    end
  end

  dwpi_mul u_mul (
    .clk     (clk),
    .gain    (mul_gain),
    .operand (mul_op),
    .term    (mul_term)
  );

  assign sum = {term_p[15], term_p} + {mul_term[15], mul_term};

  always_comb begin
    if (sum > dwpi_pkg::DRIVE_MAX) begin
      drv = 8'd255;
    end else if (sum < dwpi_pkg::DRIVE_MIN) begin
      drv = 8'd0;
    end else begin
      drv = 8'(sum + 17'sd127);
    end
  end

  assign cnt  = (pkt_r ? 9'd0 : {1'b0, silence_count}) + 9'd1;
  assign lost = cnt >= {1'b0, link_timeout};

  always_comb begin
    state_next = state;
    case (state)
      dwpi_pkg::ST_IDLE:  if (in_valid) state_next = dwpi_pkg::ST_START;
      dwpi_pkg::ST_START: state_next = dwpi_pkg::ST_DIV;
      dwpi_pkg::ST_DIV:   if (div_done) state_next = dwpi_pkg::ST_ERR;
      dwpi_pkg::ST_ERR:   state_next = dwpi_pkg::ST_MULP;
      dwpi_pkg::ST_MULP:  state_next = dwpi_pkg::ST_MULI;
      dwpi_pkg::ST_MULI:  state_next = dwpi_pkg::ST_SUM;
      dwpi_pkg::ST_SUM:   state_next = wheel ? dwpi_pkg::ST_DONE : dwpi_pkg::ST_START;
      dwpi_pkg::ST_DONE:  if (out_free) state_next = dwpi_pkg::ST_IDLE;
      default:            state_next = dwpi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    mul_gain  = prop_gain;
    mul_op    = err;
    case (state)
      dwpi_pkg::ST_IDLE:  in_stall = 1'b0;
      dwpi_pkg::ST_START: div_start = 1'b1;
      dwpi_pkg::ST_MULI: begin
        mul_gain = integ_gain;
        mul_op   = acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= dwpi_pkg::ST_IDLE;
      prop_gain      <= dwpi_pkg::PROP_GAIN_RST;
      integ_gain     <= dwpi_pkg::INTEG_GAIN_RST;
      integral_limit <= dwpi_pkg::LIMIT_RST;
      link_timeout   <= dwpi_pkg::TIMEOUT_RST;
      integ_left     <= '0;
      integ_right    <= '0;
      silence_count  <= '0;
      wheel          <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dwpi_pkg::REG_PROP_GAIN:  prop_gain      <= cfg_data;
          dwpi_pkg::REG_INTEG_GAIN: integ_gain     <= cfg_data;
          dwpi_pkg::REG_LIMIT:      integral_limit <= cfg_data[14:0];
          dwpi_pkg::REG_TIMEOUT:    link_timeout   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (state == dwpi_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        dwpi_pkg::ST_IDLE: wheel <= 1'b0;
        dwpi_pkg::ST_ERR: begin
          if (wheel) begin
            integ_right <= acc_clamp[15:0];
          end else begin
            integ_left <= acc_clamp[15:0];
          end
        end
        dwpi_pkg::ST_SUM: wheel <= 1'b1;
        dwpi_pkg::ST_DONE: begin
          if (out_free) begin
            if (link_r) begin
              silence_count <= lost ? link_timeout : cnt[7:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == dwpi_pkg::ST_IDLE && in_valid) begin
      sp_l   <= setpoint_left;
      sp_r   <= setpoint_right;
      per_l  <= period_left;
      per_r  <= period_right;
      link_r <= link_mode;
      pkt_r  <= packet_done;
    end
    if (state == dwpi_pkg::ST_ERR) begin
      err <= err_wide[15:0];
      acc <= acc_clamp[15:0];
    end
    if (state == dwpi_pkg::ST_MULI) begin
      term_p <= mul_term;
    end
    if (state == dwpi_pkg::ST_SUM) begin
      if (wheel) begin
        drv_r <= drv;
      end else begin
        drv_l <= drv;
      end
    end
    if (state == dwpi_pkg::ST_DONE && out_free) begin
      drive_left  <= (link_r && lost) ? dwpi_pkg::NEUTRAL : drv_l;
      drive_right <= (link_r && lost) ? dwpi_pkg::NEUTRAL : drv_r;
      link_ok     <= link_r && !lost;
    end
  end

endmodule

// File: tb/tb.sv
// Testbench for the dual wheel PI speed controller: directed ticks, then random ticks checked against a predictor.
`timescale 1ns / 100ps

module tb;

  localparam int PHASE_COUNT     = 8;
  localparam int TICKS_PER_PHASE = 92;
  localparam int LONG_HOLD       = 400;

  typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

  typedef struct {
    logic signed [8:0]  sp_l;
    logic signed [8:0]  sp_r;
    logic signed [17:0] per_l;
    logic signed [17:0] per_r;
    logic               link;
    logic               pkt;
  } tick_t;

  typedef struct {
    logic [7:0] left;
    logic [7:0] right;
    logic       ok;
  } drive_result_t;

  typedef struct {
    row_kind_t            kind;
    dwpi_pkg::reg_index_t idx;
    logic [15:0]          val;
    tick_t                tick;
    bit                   known;
    drive_result_t        want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic signed [8:0] setpoint_left = '0;
  logic signed [8:0] setpoint_right = '0;
  logic signed [17:0] period_left = '0;
  logic signed [17:0] period_right = '0;
  logic              link_mode = 1'b0;
  logic              packet_done = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        drive_left;
  logic [7:0]        drive_right;
  logic              link_ok;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = dwpi_pkg::REG_PROP_GAIN;
  logic [15:0]       cfg_data = '0;

  // controller copy: registers and state
  logic [15:0]        p_gain = dwpi_pkg::PROP_GAIN_RST;
  logic [15:0]        i_gain = dwpi_pkg::INTEG_GAIN_RST;
  logic [14:0]        integ_lim = dwpi_pkg::LIMIT_RST;
  logic [7:0]         link_lim = dwpi_pkg::TIMEOUT_RST;
  logic signed [15:0] integ_l = '0;
  logic signed [15:0] integ_r = '0;
  logic [7:0]         quiet_ticks = '0;

  drive_result_t pending_drives[$];
  int            fail_count = 0;
  bit            hold_results = 1'b0;
  bit            steady_run = 1'b0;

  dual_wheel_pi_speed_control_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int fold16(input longint v);
    logic signed [15:0] w;
    w = v[15:0];
    return w;
  endfunction

  function automatic int gain_term(input logic [15:0] gain, input int x);
    longint prod;
    prod = longint'(gain) * x;
    prod = prod >>> 8;
    return fold16(prod);
  endfunction

  function automatic logic [7:0] wheel_drive(input logic signed [8:0] sp,
                                             input logic signed [17:0] per,
                                             inout logic signed [15:0] integ);
    int divisor, err, acc, lim, drv;
    divisor = (per == 0) ? 1 : per;
    err = fold16(-int'(sp) - int'(dwpi_pkg::STOP_NUM) / divisor);
    lim = integ_lim;
    acc = (sp == 0) ? 0 : integ + err;
    if (acc > lim) begin
      acc = lim;
    end else if (acc < -lim) begin
      acc = -lim;
    end
    integ = acc[15:0];
    drv = gain_term(p_gain, err) + gain_term(i_gain, acc);
    if (drv > dwpi_pkg::DRIVE_MAX) begin
      drv = dwpi_pkg::DRIVE_MAX;
    end else if (drv < dwpi_pkg::DRIVE_MIN) begin
      drv = dwpi_pkg::DRIVE_MIN;
    end
    drv = drv + dwpi_pkg::NEUTRAL;
    return drv[7:0];
  endfunction

  function automatic drive_result_t predict_tick(input tick_t t);
    drive_result_t r;
    int unsigned cnt;
    r.left = wheel_drive(t.sp_l, t.per_l, integ_l);
    r.right = wheel_drive(t.sp_r, t.per_r, integ_r);
    r.ok = 1'b0;
    if (t.link) begin
      cnt = t.pkt ? 0 : quiet_ticks;
      cnt = cnt + 1;
      if (cnt >= link_lim) begin
        r.left = dwpi_pkg::NEUTRAL;
        r.right = dwpi_pkg::NEUTRAL;
        cnt = link_lim;
      end else begin
        r.ok = 1'b1;
      end
      quiet_ticks = cnt[7:0];
    end
    return r;
  endfunction

  function automatic script_row_t tick_row(input int spl, input int spr, input int perl,
                                           input int perr, input bit lnk, input bit pkt);
    script_row_t r;
    r.kind = ROW_TICK;
    r.idx = dwpi_pkg::REG_PROP_GAIN;
    r.val = '0;
    r.tick.sp_l = 9'(spl);
    r.tick.sp_r = 9'(spr);
    r.tick.per_l = 18'(perl);
    r.tick.per_r = 18'(perr);
    r.tick.link = lnk;
    r.tick.pkt = pkt;
    r.known = 1'b0;
    r.want = '{8'd0, 8'd0, 1'b0};
    return r;
  endfunction

  function automatic script_row_t check_row(input script_row_t r, input int dl, input int dr,
                                            input bit ok);
    r.known = 1'b1;
    r.want.left = 8'(dl);
    r.want.right = 8'(dr);
    r.want.ok = ok;
    return r;
  endfunction

  function automatic script_row_t reg_row(input dwpi_pkg::reg_index_t i, input int v);
    script_row_t r;
    r = tick_row(0, 0, 0, 0, 1'b0, 1'b0);
    r.kind = ROW_REG;
    r.idx = i;
    r.val = 16'(v);
    return r;
  endfunction

  function automatic logic signed [8:0] random_setpoint();
    int v;
    v = int'($urandom_range(0, 510)) - 255;
    if ($urandom_range(0, 7) == 0) begin
      v = 0;
    end
    return v[8:0];
  endfunction

  function automatic logic signed [17:0] random_period();
    int mag;
    case ($urandom_range(0, 5))
      0: mag = $urandom;
      1: mag = 0;
      2: mag = int'($urandom_range(0, 64)) - 32;
      3: mag = $urandom_range(86999, 87001);
      default: mag = $urandom_range(200, 131071);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      mag = -mag;
    end
    return mag[17:0];
  endfunction

  task automatic send_tick(input tick_t t, input bit known, input drive_result_t want);
    drive_result_t predicted;
    setpoint_left <= t.sp_l;
    setpoint_right <= t.sp_r;
    period_left <= t.per_l;
    period_right <= t.per_r;
    link_mode <= t.link;
    packet_done <= t.pkt;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_tick(t);
    if (known) begin
      pending_drives.push_back(want);
    end else begin
      pending_drives.push_back(predicted);
    end
    if (!steady_run && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input dwpi_pkg::reg_index_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      dwpi_pkg::REG_PROP_GAIN:  p_gain = val;
      dwpi_pkg::REG_INTEG_GAIN: i_gain = val;
      dwpi_pkg::REG_LIMIT:      integ_lim = val[14:0];
      dwpi_pkg::REG_TIMEOUT:    link_lim = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // result side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results = 1'b0;
        out_stall <= 1'b0;
      end else if (!steady_run && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_drives
    drive_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected result beat, drive_left %0d drive_right %0d link_ok %0d",
                 $time, drive_left, drive_right, link_ok);
        fail_count++;
      end else begin
        want = pending_drives.pop_front();
        if (drive_left !== want.left) begin
          $display("%0t: drive_left expected %0d, got %0d", $time, want.left, drive_left);
          fail_count++;
        end
        if (drive_right !== want.right) begin
          $display("%0t: drive_right expected %0d, got %0d", $time, want.right, drive_right);
          fail_count++;
        end
        if (link_ok !== want.ok) begin
          $display("%0t: link_ok expected %0d, got %0d", $time, want.ok, link_ok);
          fail_count++;
        end
      end
    end
  end

  initial begin
    script_row_t   script[$];
    tick_t         t;
    drive_result_t none;
    logic [15:0]   pg, ig;
    logic [14:0]   lim;
    logic [7:0]    tmo;
    int            link_pct, pkt_pct;
    logic signed [8:0] sp_l, sp_r;

    none = '{8'd0, 8'd0, 1'b0};
    sp_l = '0;
    sp_r = '0;

    script.push_back(check_row(tick_row(0, 0, 87001, 87001, 0, 0), 127, 127, 0));
    script.push_back(check_row(tick_row(-255, 255, 87001, 87001, 0, 0), 255, 0, 0));
    script.push_back(tick_row(0, 0, 0, 0, 0, 0));
    script.push_back(tick_row(1, -1, 1, -1, 0, 0));
    script.push_back(tick_row(255, -255, -131072, 131071, 0, 0));
    script.push_back(tick_row(100, -100, -1, 2, 0, 0));
    script.push_back(tick_row(-255, -255, 87000, -87000, 0, 1));
    script.push_back(tick_row(50, -50, -87001, 87001, 1, 1));
    script.push_back(tick_row(50, -50, 20000, -20000, 1, 0));
    script.push_back(reg_row(dwpi_pkg::REG_TIMEOUT, 2));
    script.push_back(tick_row(10, 10, 87001, 87001, 1, 1));
    script.push_back(check_row(tick_row(10, 10, 87001, 87001, 1, 0), 127, 127, 0));
    script.push_back(check_row(tick_row(-10, 20, 5, 5, 1, 0), 127, 127, 0));
    script.push_back(check_row(tick_row(0, 0, 87001, 87001, 0, 0), 127, 127, 0));
    script.push_back(tick_row(3, 3, 1000, 1000, 1, 1));
    script.push_back(reg_row(dwpi_pkg::REG_TIMEOUT, 0));
    script.push_back(check_row(tick_row(3, -3, 1000, -1000, 1, 1), 127, 127, 0));
    script.push_back(reg_row(dwpi_pkg::REG_TIMEOUT, 255));
    script.push_back(tick_row(3, -3, 1000, -1000, 1, 0));
    script.push_back(reg_row(dwpi_pkg::REG_PROP_GAIN, 16'hFFFF));
    script.push_back(reg_row(dwpi_pkg::REG_INTEG_GAIN, 16'hFFFF));
    script.push_back(reg_row(dwpi_pkg::REG_LIMIT, 15'h7FFF));
    script.push_back(tick_row(-255, 255, 1, -1, 0, 0));
    script.push_back(tick_row(-255, 255, 1, -1, 0, 0));
    script.push_back(tick_row(-255, 255, 1, -1, 0, 0));
    script.push_back(reg_row(dwpi_pkg::REG_LIMIT, 10));
    script.push_back(tick_row(1, 1, 87001, 87001, 0, 0));
    script.push_back(reg_row(dwpi_pkg::REG_PROP_GAIN, 0));
    script.push_back(reg_row(dwpi_pkg::REG_INTEG_GAIN, 0));
    script.push_back(reg_row(dwpi_pkg::REG_LIMIT, 0));
    script.push_back(check_row(tick_row(255, -255, 0, 0, 0, 0), 127, 127, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        settle_idle();
        write_reg(script[i].idx, script[i].val);
      end else begin
        send_tick(script[i].tick, script[i].known, script[i].want);
      end
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle_idle();
      if (ph == PHASE_COUNT - 1) begin
        steady_run = 1'b1;
      end
      case (ph)
        0: begin
          pg = dwpi_pkg::PROP_GAIN_RST;
          ig = dwpi_pkg::INTEG_GAIN_RST;
          lim = dwpi_pkg::LIMIT_RST;
          tmo = dwpi_pkg::TIMEOUT_RST;
        end
        1: begin
          pg = 16'hFFFF;
          ig = 16'hFFFF;
          lim = 15'h7FFF;
          tmo = 8'hFF;
        end
        2: begin
          pg = '0;
          ig = '0;
          lim = '0;
          tmo = 8'd1;
        end
        4: begin
          pg = 16'($urandom_range(0, 1024));
          ig = 16'($urandom_range(0, 512));
          lim = 15'($urandom_range(0, 40));
          tmo = 8'($urandom_range(1, 6));
        end
        default: begin
          pg = 16'($urandom_range(0, 4096));
          ig = 16'($urandom_range(0, 1024));
          lim = 15'($urandom_range(0, 32767));
          tmo = 8'($urandom_range(1, 255));
        end
      endcase
      write_reg(dwpi_pkg::REG_PROP_GAIN, pg);
      write_reg(dwpi_pkg::REG_INTEG_GAIN, ig);
      write_reg(dwpi_pkg::REG_LIMIT, {1'b0, lim});
      write_reg(dwpi_pkg::REG_TIMEOUT, {8'd0, tmo});
      link_pct = $urandom_range(20, 100);
      pkt_pct = $urandom_range(0, 100);
      if (ph == 3) begin
        hold_results = 1'b1;
      end
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          sp_l = random_setpoint();
        end
        if ($urandom_range(0, 3) == 0) begin
          sp_r = random_setpoint();
        end
        t.sp_l = sp_l;
        t.sp_r = sp_r;
        t.per_l = random_period();
        t.per_r = random_period();
        t.link = ($urandom_range(0, 99) < link_pct);
        t.pkt = ($urandom_range(0, 99) < pkt_pct);
        send_tick(t, 1'b0, none);
      end
    end

    settle_idle();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("dual_wheel_pi_speed_control_core test passed");
    end else begin
      $display("dual_wheel_pi_speed_control_core test failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("dual_wheel_pi_speed_control_core test failed");
    $finish;
  end

endmodule

// File: dual_wheel_pi_speed_control_core.f
design/dwpi_pkg.sv
design/dwpi_div.sv
design/dwpi_mul.sv
design/dual_wheel_pi_speed_control_core.sv
tb/tb.sv
